### src/pato_pkg.sv
// Package for the parent-array topological order unit.
// Holds sizes, the storage entry layout and the sequencer state type.
// It has no dependencies.
package pato_pkg;

	localparam int MAX_NODES = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int ENTRY_W   = IDX_W + 1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_EVAL,
		ST_OUT
	} pato_state_t;

endpackage

### src/pato_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; it uses no package.
module pato_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/parent_array_topological_order_unit.sv
// Top level of the parent-array topological order unit.
// Depends on pato_pkg and instantiates pato_ram for the parent table.
//
// The unit takes one request per node, each carrying whether the node has a
// parent and the parent index, and stores it at the next free slot of an
// internal table. A request with last set, or the one that fills the table
// to MAX_NODES nodes, closes the set. The unit then stops taking requests
// and emits every loaded node once, in topological order: it sweeps the
// table in index order, pass after pass, emitting each unplaced node that
// is a root or whose parent has already been emitted, so a node emitted
// early in a sweep can release a later node in the same sweep. A parent
// index at or beyond the loaded count never becomes ready. When a whole
// sweep emits nothing, the remaining nodes (cycles, self parents, dangling
// parents) are emitted in index order with from_fallback set. last_res marks
// the final node of the order, after which the unit is ready to load a new
// set. Ordering runs through a single table read port and one readiness
// check: each node visited in a sweep is read from the table, then checked,
// and each emitted node is held until out_ready is high. With N nodes the
// order needs at most N+1 sweeps.
module parent_array_topological_order_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      has_parent,
	input  logic [pato_pkg::IDX_W-1:0] parent_index,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pato_pkg::IDX_W-1:0] node_index,
	output logic                      from_fallback,
	output logic                      last_res
);

	import pato_pkg::*;

	// Sequencer state and the control decisions it makes each cycle.
	pato_state_t state_q, state_d;

	logic [CNT_W-1:0]     node_cnt_q;    // loaded nodes, also the set size
	logic [CNT_W-1:0]     placed_cnt_q;  // nodes emitted so far
	logic [CNT_W-1:0]     pass_start_q;  // emitted count when the sweep began
	logic [IDX_W-1:0]     idx_q;         // node visited in the current sweep
	logic                 fallback_q;    // current sweep is the fallback sweep
	logic [MAX_NODES-1:0] placed_q;      // one bit per node, set once emitted

	logic [IDX_W-1:0] node_index_q;
	logic             from_fallback_q;
	logic             last_res_q;

	logic               in_fire;
	logic               out_fire;
	logic               load_done;
	logic               ram_rd;
	logic [ENTRY_W-1:0] ram_rd_data;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic [IDX_W-1:0]   entry_parent;
	logic               entry_root;
	logic               parent_ok;
	logic               node_ready;
	logic               do_emit;
	logic               do_step;
	logic               pass_end;
	logic               all_done;
	logic               no_progress;

	// The table entry packs the root flag above the parent index.
	assign ram_wr_data  = {~has_parent, parent_index};
	assign entry_root   = ram_rd_data[ENTRY_W-1];
	assign entry_parent = ram_rd_data[IDX_W-1:0];

	pato_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_NODES)
	) u_parent_ram (
		.clk    (clk),
		.wr_en  (in_fire),
		.wr_addr(node_cnt_q[IDX_W-1:0]),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd),
		.rd_addr(idx_q),
		.rd_data(ram_rd_data)
	);

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// The set closes on a marked request or when the table fills up.
	assign load_done = last || ((node_cnt_q + CNT_W'(1)) == CNT_W'(MAX_NODES));

	// A parent at or beyond the loaded count is never ready.
	assign parent_ok  = ({1'b0, entry_parent} < node_cnt_q) && placed_q[entry_parent];
	assign node_ready = !placed_q[idx_q] && (fallback_q || entry_root || parent_ok);

	// Sweep bookkeeping after the current node has been dealt with.
	assign pass_end    = ({1'b0, idx_q} == (node_cnt_q - CNT_W'(1)));
	assign all_done    = (placed_cnt_q == node_cnt_q);
	assign no_progress = (placed_cnt_q == pass_start_q);

	always_comb begin
		state_d = state_q;
		ram_rd  = 1'b0;
		do_emit = 1'b0;
		do_step = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && load_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_rd  = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (node_ready) begin
					do_emit = 1'b1;
					state_d = ST_OUT;
				end else begin
					do_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (out_fire) begin
					do_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		// Moving on from a node either visits the next one, starts a new
		// sweep, or finishes the set once every node has been emitted.
		if (do_step) begin
			if (pass_end && all_done) begin
				state_d = ST_LOAD;
			end else begin
				state_d = ST_READ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q   <= '0;
			placed_cnt_q <= '0;
			pass_start_q <= '0;
			idx_q        <= '0;
			fallback_q   <= 1'b0;
			placed_q     <= '0;
		end else begin
			if (in_fire) begin
				node_cnt_q   <= node_cnt_q + CNT_W'(1);
				placed_cnt_q <= '0;
				pass_start_q <= '0;
				idx_q        <= '0;
				fallback_q   <= 1'b0;
			end
			if (do_emit) begin
				placed_q[idx_q] <= 1'b1;
				placed_cnt_q    <= placed_cnt_q + CNT_W'(1);
			end
			if (do_step) begin
				if (!pass_end) begin
					idx_q <= idx_q + IDX_W'(1);
				end else if (all_done) begin
					node_cnt_q   <= '0;
					placed_cnt_q <= '0;
					pass_start_q <= '0;
					idx_q        <= '0;
					fallback_q   <= 1'b0;
					placed_q     <= '0;
				end else begin
					// A sweep that emitted nothing hands the rest to the fallback.
					idx_q        <= '0;
					pass_start_q <= placed_cnt_q;
					if (no_progress) begin
						fallback_q <= 1'b1;
					end
				end
			end
		end
	end

	// Result register; it holds its contents until the result is taken.
	always_ff @(posedge clk) begin
		if (do_emit) begin
			node_index_q    <= idx_q;
			from_fallback_q <= fallback_q;
			last_res_q      <= ((placed_cnt_q + CNT_W'(1)) == node_cnt_q);
		end
	end

	assign node_index    = node_index_q;
	assign from_fallback = from_fallback_q;
	assign last_res      = last_res_q;

endmodule
